// File: design/assert_macros.svh
// assertion macros used by the checker file
// clocked on aclk, with and without the reset guard
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define RCS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// property checked at every edge, reset included
`define RCS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// File: design/rcs_pkg.sv
// package for the column ray setup pipeline: widths, register codes, shared types
// no dependencies
package rcs_pkg;

    localparam int SCREEN_WIDTH_DEF = 1024;
    localparam int COL_W     = 10;
    localparam int POS_W     = 24;
    localparam int DIR_W     = 18;
    localparam int RDIR_W    = 19;
    localparam int MAG_W     = 19;
    localparam int FRAC_W    = 17;
    localparam int DIST_W    = 32;
    localparam int NUM_W     = 27;
    localparam int WID_W     = 13;
    localparam int CAM_W     = 28;
    localparam int ONE_Q16   = 65536;
    localparam int DIV_Q_W   = 33;
    localparam int DIV_PER_STAGE = 3;
    localparam int DIV_STAGES    = 11;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // register index codes
    localparam logic [CFG_IDX_W-1:0] REG_POS_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y = 3'd5;

    typedef struct packed {
        logic [POS_W-1:0]        pos_x;
        logic [POS_W-1:0]        pos_y;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] plane_x;
        logic signed [DIR_W-1:0] plane_y;
    } cfg_t;

    typedef struct packed {
        logic signed [RDIR_W-1:0] rd_x;
        logic signed [RDIR_W-1:0] rd_y;
        logic [MAG_W-1:0]         mag_x;
        logic [MAG_W-1:0]         mag_y;
        logic [FRAC_W-1:0]        f_x;
        logic [FRAC_W-1:0]        f_y;
    } ray_t;

    typedef struct packed {
        logic signed [RDIR_W-1:0] rd_x;
        logic signed [RDIR_W-1:0] rd_y;
        logic                     step_neg_x;
        logic                     step_neg_y;
        logic [DIST_W-1:0]        delta_x;
        logic [DIST_W-1:0]        delta_y;
        logic [DIST_W-1:0]        side_x;
        logic [DIST_W-1:0]        side_y;
    } res_t;

endpackage

// File: design/rcs_cam.sv
// camera coordinate stages: 2*column/width - 1 in signed q16
// depends on rcs_pkg
module rcs_cam #(
    parameter int SCREEN_WIDTH = rcs_pkg::SCREEN_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [rcs_pkg::COL_W-1:0]         column,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [rcs_pkg::CAM_W-1:0]  cam
);
    import rcs_pkg::*;

    localparam int NSTG = 4;
    localparam int PROD_W = 2 * NUM_W;
    localparam int QW_W = NUM_W + WID_W;
    // reciprocal truncated; result low by at most one, fixed in the last stage
    localparam logic [NUM_W-1:0] RECIP   = NUM_W'((1 << NUM_W) / SCREEN_WIDTH);
    localparam logic [WID_W-1:0] WIDTH_C = WID_W'(SCREEN_WIDTH);

    logic [NSTG-1:0] vld_reg;
    logic [NSTG:0]   adv;

    logic [NUM_W-1:0]        num0_reg, num1_reg, num2_reg;
    logic [PROD_W-1:0]       prod1_reg;
    logic [NUM_W-1:0]        q0_reg;
    logic [QW_W-1:0]         qw_reg;
    logic signed [CAM_W-1:0] cam_reg;

    logic [QW_W-1:0]         rem;
    logic [NUM_W-1:0]        q_fix;
    logic signed [CAM_W-1:0] cam_next;

    assign adv[NSTG] = out_ready;
    for (genvar i = 0; i < NSTG; i++) begin : g_adv
        assign adv[i] = !vld_reg[i] || adv[i+1];
    end

    always_comb begin
        rem      = {{WID_W{1'b0}}, num2_reg} - qw_reg;
        q_fix    = q0_reg + NUM_W'(rem >= QW_W'(WIDTH_C));
        cam_next = $signed({1'b0, q_fix}) - $signed(CAM_W'(ONE_Q16));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NSTG; i++) begin
                if (adv[i]) begin
                    vld_reg[i] <= (i == 0) ? in_valid : vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            num0_reg <= {column, {(NUM_W - COL_W){1'b0}}};
        end
        if (adv[1]) begin
            prod1_reg <= num0_reg * RECIP;
            num1_reg  <= num0_reg;
        end
        if (adv[2]) begin
            q0_reg   <= prod1_reg[PROD_W-1:NUM_W];
            qw_reg   <= prod1_reg[PROD_W-1:NUM_W] * WIDTH_C;
            num2_reg <= num1_reg;
        end
        if (adv[3]) begin
            cam_reg <= cam_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NSTG-1];
    assign cam       = cam_reg;

endmodule

// File: design/rcs_ray.sv
// ray direction stages: dir + plane*cam, saturated, plus magnitude and grid fraction
// depends on rcs_pkg
module rcs_ray (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  rcs_pkg::cfg_t                     cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [rcs_pkg::CAM_W-1:0]  cam,
    output logic                              out_valid,
    input  logic                              out_ready,
    output rcs_pkg::ray_t                     ray
);
    import rcs_pkg::*;

    localparam int NSTG = 2;
    localparam int PROD_W = DIR_W + CAM_W;
    localparam int SUM_W = PROD_W - 16 + 1;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG:0]   adv;

    logic signed [PROD_W-1:0] prod_x_reg, prod_y_reg;
    ray_t ray_reg, ray_next;

    function automatic logic signed [RDIR_W-1:0] sat_rd(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi, lo;
        hi = SUM_W'((1 << (RDIR_W - 1)) - 1);
        lo = -SUM_W'(1 << (RDIR_W - 1));
        if (v > hi) begin
            sat_rd = hi[RDIR_W-1:0];
        end else if (v < lo) begin
            sat_rd = lo[RDIR_W-1:0];
        end else begin
            sat_rd = v[RDIR_W-1:0];
        end
    endfunction

    function automatic logic [MAG_W-1:0] mag_of(input logic signed [RDIR_W-1:0] rd);
        logic signed [RDIR_W:0] wide;
        wide = {rd[RDIR_W-1], rd};
        mag_of = rd[RDIR_W-1] ? MAG_W'(-wide) : MAG_W'(wide);
    endfunction

    // fraction to the next grid line in the step direction
    function automatic logic [FRAC_W-1:0] frac_of(input logic neg, input logic [15:0] p);
        frac_of = neg ? {1'b0, p} : FRAC_W'(ONE_Q16 - {1'b0, p});
    endfunction

    assign adv[NSTG] = out_ready;
    for (genvar i = 0; i < NSTG; i++) begin : g_adv
        assign adv[i] = !vld_reg[i] || adv[i+1];
    end

    always_comb begin
        ray_next.rd_x  = sat_rd(SUM_W'(cfg.dir_x) + SUM_W'($signed(prod_x_reg[PROD_W-1:16])));
        ray_next.rd_y  = sat_rd(SUM_W'(cfg.dir_y) + SUM_W'($signed(prod_y_reg[PROD_W-1:16])));
        ray_next.mag_x = mag_of(ray_next.rd_x);
        ray_next.mag_y = mag_of(ray_next.rd_y);
        ray_next.f_x   = frac_of(ray_next.rd_x[RDIR_W-1], cfg.pos_x[15:0]);
        ray_next.f_y   = frac_of(ray_next.rd_y[RDIR_W-1], cfg.pos_y[15:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NSTG; i++) begin
                if (adv[i]) begin
                    vld_reg[i] <= (i == 0) ? in_valid : vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            prod_x_reg <= cfg.plane_x * cam;
            prod_y_reg <= cfg.plane_y * cam;
        end
        if (adv[1]) begin
            ray_reg <= ray_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NSTG-1];
    assign ray       = ray_reg;

endmodule

// File: design/rcs_recip.sv
// pipelined restoring divider: 2^32 / |ray_dir| for both axes, three bits per stage
// depends on rcs_pkg
module rcs_recip (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  rcs_pkg::ray_t                  in_ray,
    output logic                           out_valid,
    input  logic                           out_ready,
    output rcs_pkg::ray_t                  out_ray,
    output logic [rcs_pkg::DIV_Q_W-1:0]    quo_x,
    output logic [rcs_pkg::DIV_Q_W-1:0]    quo_y
);
    import rcs_pkg::*;

    localparam int NSTG = DIV_STAGES;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG:0]   adv;

    ray_t               ray_reg [NSTG];
    logic [MAG_W-1:0]   remx_reg [NSTG];
    logic [MAG_W-1:0]   remy_reg [NSTG];
    logic [DIV_Q_W-1:0] qx_reg [NSTG];
    logic [DIV_Q_W-1:0] qy_reg [NSTG];

    assign adv[NSTG] = out_ready;
    for (genvar i = 0; i < NSTG; i++) begin : g_adv
        assign adv[i] = !vld_reg[i] || adv[i+1];
    end

    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        ray_t               ray_in;
        logic [MAG_W-1:0]   rx_in, ry_in, rx_next, ry_next;
        logic [DIV_Q_W-1:0] qx_in, qy_in, qx_next, qy_next;

        if (s == 0) begin : g_first
            assign ray_in = in_ray;
            assign rx_in  = '0;
            assign ry_in  = '0;
            assign qx_in  = '0;
            assign qy_in  = '0;
        end else begin : g_rest
            assign ray_in = ray_reg[s-1];
            assign rx_in  = remx_reg[s-1];
            assign ry_in  = remy_reg[s-1];
            assign qx_in  = qx_reg[s-1];
            assign qy_in  = qy_reg[s-1];
        end

        always_comb begin
            logic [MAG_W:0] shx, shy;
            logic           b;
            rx_next = rx_in;
            ry_next = ry_in;
            qx_next = qx_in;
            qy_next = qy_in;
            for (int j = 0; j < DIV_PER_STAGE; j++) begin
                // dividend is a one followed by zeros
                b   = ((s * DIV_PER_STAGE + j) == 0);
                shx = {rx_next, b};
                shy = {ry_next, b};
                if (shx >= {1'b0, ray_in.mag_x}) begin
                    rx_next = MAG_W'(shx - {1'b0, ray_in.mag_x});
                    qx_next = {qx_next[DIV_Q_W-2:0], 1'b1};
                end else begin
                    rx_next = MAG_W'(shx);
                    qx_next = {qx_next[DIV_Q_W-2:0], 1'b0};
                end
                if (shy >= {1'b0, ray_in.mag_y}) begin
                    ry_next = MAG_W'(shy - {1'b0, ray_in.mag_y});
                    qy_next = {qy_next[DIV_Q_W-2:0], 1'b1};
                end else begin
                    ry_next = MAG_W'(shy);
                    qy_next = {qy_next[DIV_Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[s]) begin
                ray_reg[s]  <= ray_in;
                remx_reg[s] <= rx_next;
                remy_reg[s] <= ry_next;
                qx_reg[s]   <= qx_next;
                qy_reg[s]   <= qy_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NSTG; i++) begin
                if (adv[i]) begin
                    vld_reg[i] <= (i == 0) ? in_valid : vld_reg[i-1];
                end
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NSTG-1];
    assign out_ray   = ray_reg[NSTG-1];
    assign quo_x     = qx_reg[NSTG-1];
    assign quo_y     = qy_reg[NSTG-1];

endmodule

// File: design/rcs_side.sv
// delta saturation and side distance stages; the last stage is the output register
// depends on rcs_pkg
module rcs_side (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  rcs_pkg::ray_t                in_ray,
    input  logic [rcs_pkg::DIV_Q_W-1:0]  quo_x,
    input  logic [rcs_pkg::DIV_Q_W-1:0]  quo_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output rcs_pkg::res_t                res
);
    import rcs_pkg::*;

    localparam int NSTG = 2;
    localparam int PROD_W = FRAC_W + DIST_W;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG:0]   adv;

    ray_t              ray_reg;
    logic [DIST_W-1:0] dx_reg, dy_reg, dx_next, dy_next;
    res_t              res_reg, res_next;
    logic [PROD_W-1:0] px, py;

    function automatic logic [DIST_W-1:0] sat_side(input logic [PROD_W-1:0] p);
        sat_side = p[PROD_W-1] ? DIST_MAX : p[PROD_W-2:16];
    endfunction

    assign adv[NSTG] = out_ready;
    for (genvar i = 0; i < NSTG; i++) begin : g_adv
        assign adv[i] = !vld_reg[i] || adv[i+1];
    end

    always_comb begin
        // zero direction and unit magnitude both saturate
        dx_next = (in_ray.mag_x <= MAG_W'(1)) ? DIST_MAX : quo_x[DIST_W-1:0];
        dy_next = (in_ray.mag_y <= MAG_W'(1)) ? DIST_MAX : quo_y[DIST_W-1:0];
        px = ray_reg.f_x * dx_reg;
        py = ray_reg.f_y * dy_reg;
        res_next.rd_x       = ray_reg.rd_x;
        res_next.rd_y       = ray_reg.rd_y;
        res_next.step_neg_x = ray_reg.rd_x[RDIR_W-1];
        res_next.step_neg_y = ray_reg.rd_y[RDIR_W-1];
        res_next.delta_x    = dx_reg;
        res_next.delta_y    = dy_reg;
        res_next.side_x     = sat_side(px);
        res_next.side_y     = sat_side(py);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NSTG; i++) begin
                if (adv[i]) begin
                    vld_reg[i] <= (i == 0) ? in_valid : vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            ray_reg <= in_ray;
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
        end
        if (adv[1]) begin
            res_reg <= res_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NSTG-1];
    assign res       = res_reg;

endmodule

// File: design/raycast_column_ray_setup.sv
// pipeline stages: 4 camera, 2 ray, 11 divider, 2 side
// throughput: one column per cycle while m_tready is high; the 33-bit reciprocal is split over 11 divider stages
// every stage advances when it is empty or the stage after it is moving, so bubbles close up
// reset (aresetn low, synchronous) empties the pipeline and loads the default camera
// configuration writes are always ready and take effect on the next cycle
module raycast_column_ray_setup #(
    parameter int SCREEN_WIDTH = rcs_pkg::SCREEN_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,   // column[9:0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [167:0]                        m_tdata,   // ray_dir_x, ray_dir_y, delta_dist_x,
                                                           // delta_dist_y, side_dist_x, side_dist_y
    output logic [1:0]                          m_tuser,   // step_neg_x, step_neg_y
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rcs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rcs_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import rcs_pkg::*;

    cfg_t cfg_reg;

    logic                    cam_valid, cam_ready;
    logic signed [CAM_W-1:0] cam;
    logic                    ray_valid, ray_ready;
    ray_t                    ray;
    logic                    div_valid, div_ready;
    ray_t                    div_ray;
    logic [DIV_Q_W-1:0]      quo_x, quo_y;
    res_t                    res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pos_x   <= '0;
            cfg_reg.pos_y   <= '0;
            cfg_reg.dir_x   <= DIR_W'(ONE_Q16);
            cfg_reg.dir_y   <= '0;
            cfg_reg.plane_x <= '0;
            cfg_reg.plane_y <= DIR_W'(43253);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_POS_X:   cfg_reg.pos_x   <= cfg_data;
                REG_POS_Y:   cfg_reg.pos_y   <= cfg_data;
                REG_DIR_X:   cfg_reg.dir_x   <= cfg_data[DIR_W-1:0];
                REG_DIR_Y:   cfg_reg.dir_y   <= cfg_data[DIR_W-1:0];
                REG_PLANE_X: cfg_reg.plane_x <= cfg_data[DIR_W-1:0];
                REG_PLANE_Y: cfg_reg.plane_y <= cfg_data[DIR_W-1:0];
                default: ;
            endcase
        end
    end

    rcs_cam #(.SCREEN_WIDTH(SCREEN_WIDTH)) u_cam (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .column    (s_tdata[COL_W-1:0]),
        .out_valid (cam_valid),
        .out_ready (cam_ready),
        .cam       (cam)
    );

    rcs_ray u_ray (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (cam_valid),
        .in_ready  (cam_ready),
        .cam       (cam),
        .out_valid (ray_valid),
        .out_ready (ray_ready),
        .ray       (ray)
    );

    rcs_recip u_recip (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ray_valid),
        .in_ready  (ray_ready),
        .in_ray    (ray),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_ray   (div_ray),
        .quo_x     (quo_x),
        .quo_y     (quo_y)
    );

    rcs_side u_side (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_ray    (div_ray),
        .quo_x     (quo_x),
        .quo_y     (quo_y),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {2'b00, res.side_y, res.side_x, res.delta_y, res.delta_x,
                      res.rd_y, res.rd_x};
    assign m_tuser = {res.step_neg_y, res.step_neg_x};

endmodule

// File: design/rcs_check.sv
// port-level checker for the column ray setup, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module rcs_check (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [15:0]  s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [167:0] m_tdata,
    input logic [1:0]   m_tuser,
    input logic         cfg_valid,
    input logic         cfg_ready,
    input logic [2:0]   cfg_index,
    input logic [23:0]  cfg_data
);

    // a stalled result stays offered
    `RCS_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")

    // a stalled result keeps its payload
    `RCS_ASSERT(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser),
        "result changed while stalled")

    // reset empties the pipeline
    `RCS_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result after reset")

    // an empty output stage means the whole pipe can move
    `RCS_ASSERT_ALWAYS(a_empty_ready, !m_tvalid |-> s_tready, "input blocked with empty output")

endmodule

bind raycast_column_ray_setup rcs_check u_rcs_check (.*);
